FILE: src/lcgb_pkg.sv
`timescale 1ns / 1ps

package lcgb_pkg;

    localparam int unsigned WORD_W = 32;

    // Multiplier of the generator recurrence.
    localparam logic [WORD_W-1:0] LCG_MULT = 32'd3039177861;
    localparam logic [WORD_W-1:0] FULL_SCALE = 32'hFFFF_FFFF;

    // Command codes carried in tuser.
    localparam logic [2:0] CMD_WORD  = 3'd0;
    localparam logic [2:0] CMD_HALF  = 3'd1;
    localparam logic [2:0] CMD_BYTE  = 3'd2;
    localparam logic [2:0] CMD_BIT   = 3'd3;
    localparam logic [2:0] CMD_RANGE = 3'd4;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [WORD_W-1:0] range_min;
        logic signed [WORD_W-1:0] range_max;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]        random_word;
        logic signed [WORD_W-1:0] range_value;
    } rsp_t;

endpackage

FILE: src/lcgb_core.sv
`timescale 1ns / 1ps

module lcgb_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        seed_load,
    input  logic [lcgb_pkg::WORD_W-1:0] seed_value,
    input  logic                        req_valid,
    input  lcgb_pkg::req_t              req,
    output logic                        idle,
    input  logic                        out_free,
    output logic                        rsp_valid,
    output lcgb_pkg::rsp_t              rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN,
        ST_MUL,
        ST_FOLD,
        ST_QUO,
        ST_FIN,
        ST_DONE
    } state_t;

    state_t      state_reg;
    logic [31:0] lcg_reg;
    logic [31:0] acc_reg;
    logic [3:0]  cnt_reg;
    logic [2:0]  cmd_reg;
    logic [31:0] lo_reg;
    logic [32:0] span_reg;
    logic [63:0] prod_reg;
    logic [32:0] sum_reg;
    logic [32:0] quo_reg;
    logic [31:0] range_reg;

    // Swap and span computed in offset binary so the compare is unsigned.
    logic [31:0] lo_off;
    logic [31:0] hi_off;
    logic        swap;
    logic [31:0] lo_sel;
    logic [32:0] span;
    logic [3:0]  cnt_init;

    // The one shared multiplier: generator update in ST_GEN, scaling in ST_MUL.
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_prod;
    logic [31:0] lcg_next;

    logic [32:0] fold_t;
    logic        fold_carry;
    logic [32:0] quo_next;
    logic [32:0] quo_clamp;

    always_comb begin
        lo_off = req.range_min ^ 32'h8000_0000;
        hi_off = req.range_max ^ 32'h8000_0000;
        swap   = hi_off < lo_off;
        lo_sel = swap ? req.range_max : req.range_min;
        span   = swap ? ({1'b0, lo_off} - {1'b0, hi_off} + 33'd1)
                      : ({1'b0, hi_off} - {1'b0, lo_off} + 33'd1);
    end

    always_comb begin
        unique case (req.command)
            lcgb_pkg::CMD_WORD:  cnt_init = 4'd15;
            lcgb_pkg::CMD_RANGE: cnt_init = 4'd15;
            lcgb_pkg::CMD_HALF:  cnt_init = 4'd7;
            lcgb_pkg::CMD_BYTE:  cnt_init = 4'd3;
            default:             cnt_init = 4'd0;
        endcase
    end

    always_comb begin
        if (state_reg == ST_GEN) begin
            mul_a = lcg_reg;
            mul_b = lcgb_pkg::LCG_MULT;
        end else begin
            mul_a = acc_reg;
            mul_b = span_reg[31:0];
        end
        mul_prod = {32'd0, mul_a} * {32'd0, mul_b};
        lcg_next = mul_prod[31:0] + 32'd1;
    end

    // With p = H*2^32 + L and M = 2^32 - 1, p = H*M + (H + L). The fold sum
    // H + L is A*2^32 + B, which again is A*M + (A + B), and A + B < 2*M.
    always_comb begin
        fold_carry = sum_reg[32];
        fold_t     = {32'd0, fold_carry} + {1'b0, sum_reg[31:0]};
        quo_next   = {1'b0, prod_reg[63:32]} + {32'd0, fold_carry}
                   + {32'd0, (fold_t >= {1'b0, lcgb_pkg::FULL_SCALE})};
        // An all-ones draw lands exactly on the span; pull it back to max.
        quo_clamp  = (quo_reg >= span_reg) ? (span_reg - 33'd1) : quo_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            lcg_reg   <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            cmd_reg   <= '0;
        end else begin
            if (seed_load) begin
                lcg_reg <= seed_value;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (req_valid) begin
                        cmd_reg  <= req.command;
                        acc_reg  <= '0;
                        cnt_reg  <= cnt_init;
                        lo_reg   <= lo_sel;
                        span_reg <= span;
                        if (req.command <= lcgb_pkg::CMD_RANGE) begin
                            state_reg <= ST_GEN;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_GEN: begin
                    lcg_reg <= lcg_next;
                    acc_reg <= {acc_reg[29:0], lcg_next[31:30]};
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == 4'd0) begin
                        state_reg <= (cmd_reg == lcgb_pkg::CMD_RANGE) ? ST_MUL : ST_DONE;
                    end
                end
                ST_MUL: begin
                    // A full-width span only occurs with a zero low part.
                    prod_reg  <= span_reg[32] ? {acc_reg, 32'd0} : mul_prod;
                    state_reg <= ST_FOLD;
                end
                ST_FOLD: begin
                    sum_reg   <= {1'b0, prod_reg[63:32]} + {1'b0, prod_reg[31:0]};
                    state_reg <= ST_QUO;
                end
                ST_QUO: begin
                    quo_reg   <= quo_next;
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    range_reg <= lo_reg + quo_clamp[31:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign idle      = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE) && out_free;

    always_comb begin
        case (cmd_reg)
            lcgb_pkg::CMD_WORD: rsp.random_word = acc_reg;
            lcgb_pkg::CMD_HALF: rsp.random_word = {16'd0, acc_reg[15:0]};
            lcgb_pkg::CMD_BYTE: rsp.random_word = {24'd0, acc_reg[7:0]};
            lcgb_pkg::CMD_BIT:  rsp.random_word = {31'd0, acc_reg[1]};
            default:            rsp.random_word = '0;
        endcase
        rsp.range_value = (cmd_reg == lcgb_pkg::CMD_RANGE) ? range_reg : '0;
    end

endmodule

FILE: src/lcg_top_bit_random_generator.sv
`timescale 1ns / 1ps
// Word, half, byte and range items run the generator until their bits are collected, bit runs it once,
// and an unused command code skips generation and returns zeros.
// One generator update per cycle goes through a single shared 32x32 multiplier;
// range mode then scales the draw in ST_MUL, ST_FOLD, ST_QUO and ST_FIN, reusing the multiplier in ST_MUL.
// A new item is taken in the cycle after the previous result is handed to the output register.
// Synchronous active-low reset clears the generator state to zero; a seed write reloads it.

module lcg_top_bit_random_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // range_min [31:0], range_max [63:32]
    input  logic [2:0]  s_axis_tuser,   // command [2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // random_word [31:0], range_value [63:32]
);

    lcgb_pkg::req_t req;
    lcgb_pkg::rsp_t rsp;
    logic           core_idle;
    logic           rsp_valid;
    logic           out_free;
    logic           m_valid_reg;
    logic [63:0]    m_data_reg;

    // The seed is taken only between items so an update in progress cannot overwrite it.
    assign cfg_ready     = core_idle;
    assign s_axis_tready = core_idle;

    always_comb begin
        req.command   = s_axis_tuser;
        req.range_min = s_axis_tdata[31:0];
        req.range_max = s_axis_tdata[63:32];
    end

    // The output register frees up in the same cycle its item is taken.
    assign out_free = !m_valid_reg || m_axis_tready;

    lcgb_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .seed_load  (cfg_valid && cfg_ready),
        .seed_value (cfg_data),
        .req_valid  (s_axis_tvalid),
        .req        (req),
        .idle       (core_idle),
        .out_free   (out_free),
        .rsp_valid  (rsp_valid),
        .rsp        (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (rsp_valid) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {rsp.range_value, rsp.random_word};
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

    localparam int ITEMS_PER_SEED = 280;
    localparam int HOLD_AFTER     = 500;
    localparam int HOLD_CYCLES    = 400;
    localparam int QUIET_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 40;
    localparam int REPORT_LIMIT   = 10;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;   // range_min [31:0], range_max [63:32]
    logic [2:0]  s_axis_tuser  = '0;   // command [2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // random_word [31:0], range_value [63:32]

    lcg_top_bit_random_generator DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    lcgb_pkg::req_t req_backlog[$];
    lcgb_pkg::rsp_t pending_draws[$];
    logic [31:0]    lcg_state = '0;
    int             requests_queued = 0;
    int             draws_returned  = 0;
    int             failures        = 0;
    int             requests_sent   = 0;
    int             send_gap        = 0;
    int             recv_stall      = 0;
    int             quiet_cycles    = 0;

    // Both sides idle at random, except for one stretch of 40 items in every 160.
    function automatic int idle_cycles(int seq);
        if ((seq / 40) % 4 == 3) begin
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [31:0] advance_state();
        lcg_state = lcg_state * lcgb_pkg::LCG_MULT + 32'd1;
        return lcg_state;
    endfunction

    function automatic logic [31:0] collect_top_bits(int updates);
        logic [31:0] acc;
        logic [31:0] x;
        acc = '0;
        for (int i = 0; i < updates; i++) begin
            x   = advance_state();
            acc = {acc[29:0], x[31:30]};
        end
        return acc;
    endfunction

    function automatic lcgb_pkg::rsp_t predict_draw(logic [2:0] cmd, logic [31:0] lo_in,
                                                    logic [31:0] hi_in);
        lcgb_pkg::rsp_t     r;
        logic [31:0]        x;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] t;
        logic [63:0]        span;
        logic [63:0]        scaled;
        r  = '0;
        lo = lo_in;
        hi = hi_in;
        case (cmd)
            lcgb_pkg::CMD_WORD: r.random_word = collect_top_bits(16);
            lcgb_pkg::CMD_HALF: r.random_word = collect_top_bits(8);
            lcgb_pkg::CMD_BYTE: r.random_word = collect_top_bits(4);
            lcgb_pkg::CMD_BIT: begin
                x = advance_state();
                r.random_word = {31'd0, x[31]};
            end
            lcgb_pkg::CMD_RANGE: begin
                if (hi < lo) begin
                    t  = lo;
                    lo = hi;
                    hi = t;
                end
                span   = {{32{hi[31]}}, hi} - {{32{lo[31]}}, lo} + 64'd1;
                scaled = ({32'd0, collect_top_bits(16)} * span)
                       / {32'd0, lcgb_pkg::FULL_SCALE};
                // An all-ones word would land one past max.
                if (scaled >= span) begin
                    scaled = span - 64'd1;
                end
                r.range_value = lo + scaled[31:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_failure(string msg);
        failures++;
        if (failures <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endtask

    task automatic add_request(logic [2:0] cmd, logic signed [31:0] lo,
                               logic signed [31:0] hi);
        lcgb_pkg::req_t item;
        item.command   = cmd;
        item.range_min = lo;
        item.range_max = hi;
        req_backlog.push_back(item);
        requests_queued++;
    endtask

    task automatic add_random_request();
        logic [2:0]         cmd;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        int                 pick;
        pick = $urandom_range(0, 19);
        if (pick < 4) cmd = lcgb_pkg::CMD_WORD;
        else if (pick < 7) cmd = lcgb_pkg::CMD_HALF;
        else if (pick < 10) cmd = lcgb_pkg::CMD_BYTE;
        else if (pick < 13) cmd = lcgb_pkg::CMD_BIT;
        else if (pick < 19) cmd = lcgb_pkg::CMD_RANGE;
        else cmd = CMD_SPARE_5 + 3'($urandom_range(0, 2));
        lo = $urandom;
        hi = $urandom;
        case ($urandom_range(0, 5))
            0: ;
            1: hi = lo + 32'($urandom_range(0, 15));
            2: begin
                lo = ($urandom_range(0, 1) != 0) ? S32_MIN : S32_MAX;
                hi = ($urandom_range(0, 1) != 0) ? S32_MIN : S32_MAX;
            end
            3: hi = lo;
            4: begin
                lo = $signed(32'($urandom_range(0, 64))) - 32'sd32;
                hi = $signed(32'($urandom_range(0, 64))) - 32'sd32;
            end
            default: begin
                lo = $urandom_range(0, 1000);
                hi = -lo;
            end
        endcase
        add_request(cmd, lo, hi);
    endtask

    task automatic wait_drained();
        while (draws_returned < requests_queued) begin
            @(posedge aclk);
        end
    endtask

    task automatic load_seed(logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        lcg_state = value;
        cfg_valid <= 1'b0;
    endtask

    // Driver: presents queued requests, predicting each one as it is accepted.
    always @(posedge aclk) begin
        logic           next_valid;
        lcgb_pkg::req_t item;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                pending_draws.push_back(predict_draw(s_axis_tuser, s_axis_tdata[31:0],
                                                     s_axis_tdata[63:32]));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (req_backlog.size() != 0) begin
                    item = req_backlog.pop_front();
                    s_axis_tuser <= item.command;
                    s_axis_tdata <= {item.range_max, item.range_min};
                    next_valid = 1'b1;
                    send_gap = idle_cycles(requests_sent);
                    requests_sent++;
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Monitor: checks each result and paces m_axis_tready.
    always @(posedge aclk) begin
        lcgb_pkg::rsp_t want;
        logic [31:0]    got_word;
        logic [31:0]    got_range;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_word  = m_axis_tdata[31:0];
                got_range = m_axis_tdata[63:32];
                draws_returned++;
                if (pending_draws.size() == 0) begin
                    note_failure($sformatf("unexpected result: word=%h range=%h",
                                           got_word, got_range));
                end else begin
                    want = pending_draws.pop_front();
                    if (got_word !== want.random_word || got_range !== want.range_value) begin
                        note_failure($sformatf(
                            "mismatch on result %0d: word exp=%h got=%h, range exp=%h got=%h",
                            draws_returned, want.random_word, got_word,
                            want.range_value, got_range));
                    end
                end
                // One long hold lets the block back up and stall its input.
                recv_stall = (draws_returned == HOLD_AFTER) ? HOLD_CYCLES
                                                            : idle_cycles(draws_returned);
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
            m_axis_tready <= (recv_stall == 0);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [31:0] seeds[6];
        seeds[0] = 32'hFFFF_FFFF;
        seeds[1] = 32'h0000_0000;
        seeds[2] = $urandom;
        seeds[3] = 32'h8000_0000;
        seeds[4] = 32'h0000_0001;
        seeds[5] = $urandom;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests from the reset state.
        add_request(lcgb_pkg::CMD_WORD, S32_MIN, S32_MAX);
        add_request(lcgb_pkg::CMD_HALF, 32'sd0, 32'sd0);
        add_request(lcgb_pkg::CMD_BYTE, -32'sd1, -32'sd1);
        add_request(lcgb_pkg::CMD_BIT, S32_MAX, S32_MIN);
        add_request(lcgb_pkg::CMD_BIT, 32'sd0, -32'sd1);
        add_request(lcgb_pkg::CMD_RANGE, S32_MIN, S32_MAX);
        add_request(lcgb_pkg::CMD_RANGE, S32_MAX, S32_MIN);
        add_request(lcgb_pkg::CMD_RANGE, 32'sd0, 32'sd0);
        add_request(lcgb_pkg::CMD_RANGE, S32_MIN, S32_MIN);
        add_request(lcgb_pkg::CMD_RANGE, S32_MAX, S32_MAX);
        add_request(lcgb_pkg::CMD_RANGE, -32'sd1, 32'sd0);
        add_request(lcgb_pkg::CMD_RANGE, 32'sd0, 32'sd1);
        add_request(lcgb_pkg::CMD_RANGE, 32'sd10, -32'sd10);
        add_request(lcgb_pkg::CMD_RANGE, -32'sd100, 32'sd100);
        add_request(lcgb_pkg::CMD_RANGE, S32_MIN, -32'sd1);
        add_request(lcgb_pkg::CMD_RANGE, 32'sd0, S32_MAX);
        add_request(CMD_SPARE_5, -32'sd1, -32'sd1);
        add_request(CMD_SPARE_6, S32_MIN, S32_MAX);
        add_request(CMD_SPARE_7, 32'sh1234_5678, -32'sd1);
        add_request(lcgb_pkg::CMD_WORD, -32'sd1, -32'sd1);
        add_request(lcgb_pkg::CMD_RANGE, 32'sd5, 32'sd7);
        wait_drained();

        foreach (seeds[p]) begin
            load_seed(seeds[p]);
            for (int n = 0; n < ITEMS_PER_SEED; n++) begin
                add_random_request();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_draws.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", pending_draws.size()));
        end
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
